[sv/sha1md_pkg.sv]
// Shared types and constants for the SHA-1 message digest block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sha1md_pkg;

	// Initial chaining value.
	localparam logic [31:0] H0 = 32'h6745_2301;
	localparam logic [31:0] H1 = 32'hefcd_ab89;
	localparam logic [31:0] H2 = 32'h98ba_dcfe;
	localparam logic [31:0] H3 = 32'h1032_5476;
	localparam logic [31:0] H4 = 32'hc3d2_e1f0;

	// Round constants, one for each group of twenty rounds.
	localparam logic [31:0] K0 = 32'h5a82_7999;
	localparam logic [31:0] K1 = 32'h6ed9_eba1;
	localparam logic [31:0] K2 = 32'h8f1b_bcdc;
	localparam logic [31:0] K3 = 32'hca62_c1d6;

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam int ROUNDS = 80;
	localparam int RND_W  = 7;

	localparam logic [2:0] LAST_DIGEST_IDX = 3'd4;

	// Source of a word shifted into the block buffer.
	typedef logic [2:0] src_t;
	localparam src_t SRC_WORD  = 3'd0;
	localparam src_t SRC_PAD   = 3'd1;
	localparam src_t SRC_80    = 3'd2;
	localparam src_t SRC_ZERO  = 3'd3;
	localparam src_t SRC_LENHI = 3'd4;
	localparam src_t SRC_LENLO = 3'd5;

	typedef struct packed {
		logic             append;
		src_t             src;
		logic             round;
		logic [RND_W-1:0] rnd;
		logic             final_add;
		logic             load_out;
		logic [2:0]       out_idx;
		logic             clear;
	} cmd_t;

	typedef struct packed {
		logic pos_last;
		logic pos_len;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

[sv/sha1md_msg_if.sv]
// Message word channel: valid/ready handshake with the message payload.
// Stands alone; used by the top level of the SHA-1 digest block.
`timescale 1ns / 1ps
`default_nettype none
interface sha1md_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_word;
	logic [2:0]  valid_bytes;
	logic        last_word;

	modport source(output valid, message_word, valid_bytes, last_word, input ready);
	modport sink(input valid, message_word, valid_bytes, last_word, output ready);
endinterface
`default_nettype wire

[sv/sha1md_dig_if.sv]
// Digest word channel: valid/ready handshake with one digest word per transaction.
// Stands alone; used by the top level of the SHA-1 digest block.
`timescale 1ns / 1ps
`default_nettype none
interface sha1md_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;

	modport source(output valid, digest_word, digest_index, digest_last, input ready);
	modport sink(input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

[sv/sha1md_dpath.sv]
// Datapath: chaining value, block buffer as a message schedule shift line,
// working variables, byte count and the digest output register. Uses sha1md_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1md_pkg::cmd_t  cmd,
	output sha1md_pkg::sts_t  sts,
	input  logic [31:0]       message_word,
	input  logic [1:0]        valid_bytes,
	input  logic              dig_ready,
	output logic              dig_valid,
	output logic [31:0]       digest_word,
	output logic [2:0]        digest_index,
	output logic              digest_last
);

	logic [31:0] chain_q [5];
	logic [31:0] sched_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [3:0]  pos_q;
	logic [60:0] total_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;

	logic [31:0] pad_word;
	logic [31:0] new_word;
	logic [31:0] wt;
	logic [31:0] mix;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] tmp;
	logic [31:0] out_sel;
	logic [60:0] byte_add;

	// Final word with fewer than four valid bytes: clear the tail, then mark it.
	always_comb begin
		case (valid_bytes)
			2'd0: pad_word = sha1md_pkg::PAD_WORD;
			2'd1: pad_word = {message_word[31:24], sha1md_pkg::PAD_BYTE, 16'h0000};
			2'd2: pad_word = {message_word[31:16], sha1md_pkg::PAD_BYTE, 8'h00};
			2'd3: pad_word = {message_word[31:8], sha1md_pkg::PAD_BYTE};
			default: pad_word = sha1md_pkg::PAD_WORD;
		endcase
	end

	always_comb begin
		case (cmd.src)
			sha1md_pkg::SRC_WORD:  new_word = message_word;
			sha1md_pkg::SRC_PAD:   new_word = pad_word;
			sha1md_pkg::SRC_80:    new_word = sha1md_pkg::PAD_WORD;
			sha1md_pkg::SRC_ZERO:  new_word = 32'h0000_0000;
			sha1md_pkg::SRC_LENHI: new_word = total_q[60:29];
			sha1md_pkg::SRC_LENLO: new_word = {total_q[28:0], 3'b000};
			default:               new_word = 32'h0000_0000;
		endcase
	end

	always_comb begin
		case (cmd.src)
			sha1md_pkg::SRC_WORD: byte_add = 61'd4;
			sha1md_pkg::SRC_PAD:  byte_add = {59'd0, valid_bytes};
			default:              byte_add = 61'd0;
		endcase
	end

	// The shift line holds w[t-16] .. w[t-1], so the schedule taps sit at fixed places.
	assign mix = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign wt  = (cmd.rnd < 7'd16) ? sched_q[0] : {mix[30:0], mix[31]};

	always_comb begin
		if (cmd.rnd < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1md_pkg::K0;
		end else if (cmd.rnd < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1md_pkg::K1;
		end else if (cmd.rnd < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1md_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1md_pkg::K3;
		end
	end

	assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;

	always_comb begin
		case (cmd.out_idx)
			3'd0:    out_sel = chain_q[0];
			3'd1:    out_sel = chain_q[1];
			3'd2:    out_sel = chain_q[2];
			3'd3:    out_sel = chain_q[3];
			default: out_sel = chain_q[4];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.append || cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= cmd.append ? new_word : wt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && (pos_q == 4'd15)) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= sha1md_pkg::H0;
			chain_q[1] <= sha1md_pkg::H1;
			chain_q[2] <= sha1md_pkg::H2;
			chain_q[3] <= sha1md_pkg::H3;
			chain_q[4] <= sha1md_pkg::H4;
			pos_q      <= 4'd0;
			total_q    <= 61'd0;
		end else if (cmd.clear) begin
			chain_q[0] <= sha1md_pkg::H0;
			chain_q[1] <= sha1md_pkg::H1;
			chain_q[2] <= sha1md_pkg::H2;
			chain_q[3] <= sha1md_pkg::H3;
			chain_q[4] <= sha1md_pkg::H4;
			pos_q      <= 4'd0;
			total_q    <= 61'd0;
		end else begin
			if (cmd.final_add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.append) begin
				pos_q   <= pos_q + 4'd1;
				total_q <= total_q + byte_add;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (dig_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_word_q <= out_sel;
			out_idx_q  <= cmd.out_idx;
			out_last_q <= (cmd.out_idx == sha1md_pkg::LAST_DIGEST_IDX);
		end
	end

	assign sts.pos_last = (pos_q == 4'd15);
	assign sts.pos_len  = (pos_q == 4'd14);
	assign sts.out_busy = out_valid_q && !dig_ready;

	assign dig_valid    = out_valid_q;
	assign digest_word  = out_word_q;
	assign digest_index = out_idx_q;
	assign digest_last  = out_last_q;

endmodule
`default_nettype wire

[sv/sha1md_ctrl.sv]
// Controller: sequences word intake, padding, the 80 compression rounds and
// the five digest transactions. Uses sha1md_pkg; drives sha1md_dpath by command.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	input  logic              last_word,
	input  logic              last_full,
	output logic              msg_ready,
	output sha1md_pkg::cmd_t  cmd,
	input  sha1md_pkg::sts_t  sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD80 = 3'd1;
	localparam logic [2:0] S_ZERO  = 3'd2;
	localparam logic [2:0] S_LENLO = 3'd3;
	localparam logic [2:0] S_ROUND = 3'd4;
	localparam logic [2:0] S_FINAL = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]                   state_q, state_d;
	logic [2:0]                   ret_q, ret_d;
	logic [2:0]                   next_s;
	logic [sha1md_pkg::RND_W-1:0] rnd_q, rnd_d;
	logic [2:0]                   idx_q, idx_d;

	always_comb begin
		cmd         = '0;
		cmd.rnd     = rnd_q;
		cmd.out_idx = idx_q;
		msg_ready   = 1'b0;
		state_d     = state_q;
		ret_d       = ret_q;
		rnd_d       = rnd_q;
		idx_d       = idx_q;
		next_s      = state_q;
		case (state_q)
			S_IDLE: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					cmd.append = 1'b1;
					if (!last_word) begin
						cmd.src = sha1md_pkg::SRC_WORD;
						next_s  = S_IDLE;
					end else if (last_full) begin
						cmd.src = sha1md_pkg::SRC_WORD;
						next_s  = S_PAD80;
					end else begin
						cmd.src = sha1md_pkg::SRC_PAD;
						next_s  = S_ZERO;
					end
				end
			end
			S_PAD80: begin
				cmd.append = 1'b1;
				cmd.src    = sha1md_pkg::SRC_80;
				next_s     = S_ZERO;
			end
			S_ZERO: begin
				// Zero fill runs until the two length words close the block.
				cmd.append = 1'b1;
				if (sts.pos_len) begin
					cmd.src = sha1md_pkg::SRC_LENHI;
					next_s  = S_LENLO;
				end else begin
					cmd.src = sha1md_pkg::SRC_ZERO;
					next_s  = S_ZERO;
				end
			end
			S_LENLO: begin
				cmd.append = 1'b1;
				cmd.src    = sha1md_pkg::SRC_LENLO;
				next_s     = S_OUT;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 7'd1;
				if (rnd_q == 7'(sha1md_pkg::ROUNDS - 1)) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.final_add = 1'b1;
				state_d       = ret_q;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					if (idx_q == sha1md_pkg::LAST_DIGEST_IDX) begin
						cmd.clear = 1'b1;
						idx_d     = 3'd0;
						state_d   = S_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// A word that fills the buffer starts the compression first.
		if (cmd.append) begin
			if (sts.pos_last) begin
				state_d = S_ROUND;
				ret_d   = next_s;
				rnd_d   = '0;
			end else begin
				state_d = next_s;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			rnd_q   <= '0;
			idx_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			rnd_q   <= rnd_d;
			idx_q   <= idx_d;
		end
	end

endmodule
`default_nettype wire

[sv/sha1_message_digest.sv]
// SHA-1 message digest, streaming.
// Message words arrive on msg (valid/ready), first byte in bits 31:24. Every
// word but the final one carries four bytes; the final word, flagged by
// last_word, carries valid_bytes bytes (0 to 4) and triggers padding. The
// digest leaves on dig as five transactions, most significant word first,
// digest_index 0 to 4, digest_last on the fifth.
// Timing: a word that completes a 16-word block holds ready low while the
// block is compressed: 80 rounds on the single round unit, one round per
// cycle, then the chaining add. After the final word, padding appends up
// to 18 padding words and runs one or two compressions; after the last
// block's chaining add, the first digest word is loaded into the output
// register once that register is free or being taken.
// Digest words sit in an output register; a stall on dig holds them there and
// holds the block. The last digest word may wait there while the next message
// is already being taken. Reset restores the initial chaining value and an
// empty buffer and byte count, as does loading the fifth digest word.
// Depends on sha1md_pkg, sha1md_msg_if, sha1md_dig_if, sha1md_ctrl, sha1md_dpath.
`timescale 1ns / 1ps
`default_nettype none
module sha1_message_digest (
	input  logic         clk,
	input  logic         arst_n,
	sha1md_msg_if.sink   msg,
	sha1md_dig_if.source dig
);

	sha1md_pkg::cmd_t cmd;
	sha1md_pkg::sts_t sts;
	logic             last_full;

	// Five to seven valid bytes count as four.
	assign last_full = msg.valid_bytes[2];

	sha1md_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg.valid),
		.last_word (msg.last_word),
		.last_full (last_full),
		.msg_ready (msg.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	sha1md_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.message_word (msg.message_word),
		.valid_bytes  (msg.valid_bytes[1:0]),
		.dig_ready    (dig.ready),
		.dig_valid    (dig.valid),
		.digest_word  (dig.digest_word),
		.digest_index (dig.digest_index),
		.digest_last  (dig.digest_last)
	);

	// The final word always leads into padding, so intake must pause after it.
	a_last_pauses: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready && msg.last_word) |=> !msg.ready)
		else $error("message intake did not pause after the final word");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> (dig.digest_last ==
		(dig.digest_index == sha1md_pkg::LAST_DIGEST_IDX)))
		else $error("digest_last does not match the fifth digest word");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(dig.valid && dig.ready && !dig.digest_last) |=>
		(dig.valid && (dig.digest_index == ($past(dig.digest_index) + 3'd1))))
		else $error("digest words not delivered in consecutive order");

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the streaming SHA-1 message digest block.
// Depends on sha1_message_digest and its interfaces sha1md_msg_if and sha1md_dig_if.
`timescale 1ns / 1ps
module tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int RANDOM_ITEMS   = 410;

	// SHA-1 constants, held locally so that the check does not lean on the design's own copy.
	localparam logic [31:0] IV [5] = '{32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe,
		32'h1032_5476, 32'hc3d2_e1f0};
	localparam logic [31:0] ROUND_K [4] = '{32'h5a82_7999, 32'h6ed9_eba1,
		32'h8f1b_bcdc, 32'hca62_c1d6};
	localparam logic [31:0] MARKER_WORD = 32'h8000_0000;
	localparam logic [31:0] MARKER_BYTE = 32'h0000_0080;
	localparam logic [2:0]  FULL_WORD   = 3'd4;
	localparam logic [2:0]  FINAL_INDEX = 3'd4;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} msg_item_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_item_t;

	logic clk;
	logic arst_n;

	sha1md_msg_if msg_ch ();
	sha1md_dig_if dig_ch ();

	sha1_message_digest u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.dig    (dig_ch)
	);

	msg_item_t    words_to_send [$];
	digest_item_t digests_due [$];
	int           mismatches;
	int           words_taken;
	int           quiet_cycles;
	logic         steady;

	// Running SHA-1 state of the predictor.
	logic [31:0] hash_state [5];
	logic [31:0] block_words [16];
	int          block_fill;
	logic [60:0] byte_count;

	// With no idling on either side for a stretch of the run.
	assign steady = (words_taken >= 160) && (words_taken < 240);

	task automatic hash_restart();
		hash_state = IV;
		foreach (block_words[i])
			block_words[i] = '0;
		block_fill = 0;
		byte_count = '0;
	endtask

	task automatic hash_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, wt, sum;
		w = block_words;
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int t = 0; t < 80; t++) begin
			if (t < 16) begin
				wt = w[t];
			end else begin
				wt = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
				wt = {wt[30:0], wt[31]};
				w[t % 16] = wt;
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = ROUND_K[0];
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = ROUND_K[1];
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = ROUND_K[2];
			end else begin
				f = b ^ c ^ d;
				k = ROUND_K[3];
			end
			sum = {a[26:0], a[31:27]} + f + e + k + wt;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = sum;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endtask

	task automatic hash_append(input logic [31:0] word);
		block_words[block_fill] = word;
		block_fill++;
		if (block_fill == 16) begin
			hash_compress();
			foreach (block_words[i])
				block_words[i] = '0;
			block_fill = 0;
		end
	endtask

	// Absorbs one message word; a final word pads the message and queues the digest.
	task automatic hash_absorb(input msg_item_t item);
		logic [2:0]  nb;
		logic [31:0] keep;
		logic [63:0] bit_len;
		digest_item_t dw;
		if (!item.last) begin
			byte_count += 61'd4;
			hash_append(item.word);
			return;
		end
		nb = (item.nbytes > FULL_WORD) ? FULL_WORD : item.nbytes;
		if (nb == FULL_WORD) begin
			byte_count += 61'd4;
			hash_append(item.word);
			hash_append(MARKER_WORD);
		end else begin
			case (nb)
				3'd1: keep = 32'hff00_0000;
				3'd2: keep = 32'hffff_0000;
				3'd3: keep = 32'hffff_ff00;
				default: keep = 32'h0000_0000;
			endcase
			byte_count += 61'(nb);
			hash_append((item.word & keep) | (MARKER_BYTE << (24 - 8 * nb)));
		end
		// The 64-bit length needs the last two words of a block to itself.
		if (block_fill > 14) begin
			for (int i = block_fill; i < 16; i++)
				block_words[i] = '0;
			hash_compress();
			block_fill = 0;
		end
		for (int i = block_fill; i < 14; i++)
			block_words[i] = '0;
		bit_len = {byte_count, 3'b000};
		block_words[14] = bit_len[63:32];
		block_words[15] = bit_len[31:0];
		hash_compress();
		for (int i = 0; i < 5; i++) begin
			dw.word  = hash_state[i];
			dw.index = 3'(i);
			dw.last  = (3'(i) == FINAL_INDEX);
			digests_due.push_back(dw);
		end
		hash_restart();
	endtask

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 32'h0000_0000;
		if (r == 1)
			return 32'hffff_ffff;
		return $urandom;
	endfunction

	task automatic queue_word(input logic [31:0] word, input logic [2:0] nb, input logic last);
		msg_item_t item;
		item.word   = word;
		item.nbytes = nb;
		item.last   = last;
		words_to_send.push_back(item);
	endtask

	// Body words carry a random byte count, which the block must ignore.
	task automatic queue_message(input int body_words, input logic [2:0] final_nb);
		for (int i = 0; i < body_words; i++)
			queue_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
		queue_word(pick_word(), final_nb, 1'b1);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Message side: presents one word at a time and feeds each accepted one to the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_ch.valid        <= 1'b0;
			msg_ch.message_word <= '0;
			msg_ch.valid_bytes  <= '0;
			msg_ch.last_word    <= 1'b0;
			words_taken         <= 0;
		end else begin
			if (msg_ch.valid && msg_ch.ready) begin
				hash_absorb('{msg_ch.message_word, msg_ch.valid_bytes, msg_ch.last_word});
				words_taken <= words_taken + 1;
			end
			if (!msg_ch.valid || msg_ch.ready) begin
				if (words_to_send.size() > 0 && (steady || $urandom_range(0, 99) >= 37)) begin
					msg_item_t item;
					item = words_to_send.pop_front();
					msg_ch.valid        <= 1'b1;
					msg_ch.message_word <= item.word;
					msg_ch.valid_bytes  <= item.nbytes;
					msg_ch.last_word    <= item.last;
				end else begin
					msg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Digest side: random back-pressure, each transaction checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
		end else begin
			if (dig_ch.valid && dig_ch.ready) begin
				if (digests_due.size() == 0) begin
					$error("digest word %h (index %0d) arrived with none outstanding",
						dig_ch.digest_word, dig_ch.digest_index);
					mismatches++;
				end else begin
					digest_item_t exp_d;
					exp_d = digests_due.pop_front();
					if (dig_ch.digest_word !== exp_d.word) begin
						$error("digest_word: expected %h, got %h", exp_d.word, dig_ch.digest_word);
						mismatches++;
					end
					if (dig_ch.digest_index !== exp_d.index) begin
						$error("digest_index: expected %0d, got %0d", exp_d.index,
							dig_ch.digest_index);
						mismatches++;
					end
					if (dig_ch.digest_last !== exp_d.last) begin
						$error("digest_last: expected %b, got %b", exp_d.last, dig_ch.digest_last);
						mismatches++;
					end
				end
			end
			dig_ch.ready <= steady || ($urandom_range(0, 99) >= 37);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		int body;
		int final_nb;
		int items_total;
		arst_n              = 1'b0;
		msg_ch.valid        = 1'b0;
		msg_ch.message_word = '0;
		msg_ch.valid_bytes  = '0;
		msg_ch.last_word    = 1'b0;
		dig_ch.ready        = 1'b0;
		mismatches          = 0;
		quiet_cycles        = 0;
		hash_restart();

		// Short messages: empty, partial final words with junk in the dropped bytes,
		// and over-range byte counts that must count as a full word.
		queue_word(32'hdead_beef, 3'd0, 1'b1);
		queue_word(32'h6162_63ff, 3'd3, 1'b1);
		queue_word(32'hffff_ffff, 3'd1, 1'b1);
		queue_word(32'h1234_5678, 3'd2, 1'b1);
		queue_word(32'hffff_ffff, 3'd5, 1'b1);
		queue_word(32'h0000_0000, 3'd6, 1'b1);
		queue_word(32'ha5a5_5a5a, 3'd7, 1'b1);
		queue_word(32'h0000_0000, 3'd0, 1'b0);
		queue_word(32'hffff_ffff, 3'd4, 1'b1);
		// Fourteen full words leave no room for the length, forcing a second padding block.
		queue_message(13, FULL_WORD);

		while (words_to_send.size() < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 5)
				body = $urandom_range(0, 6);
			else if (kind < 8)
				body = $urandom_range(12, 17);
			else if (kind == 8)
				body = $urandom_range(28, 33);
			else
				body = $urandom_range(0, 40);
			final_nb = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			queue_message(body, 3'(final_nb));
		end
		items_total = words_to_send.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Every word must be taken and every predicted digest word delivered.
		while (words_taken < items_total)
			@(posedge clk);
		while (digests_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && digests_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
